FILE: sv/aaf_pkg.sv
// Package for the adjacent anagram filter.
// Shared beat fields and control struct; no dependencies.
package aaf_pkg;

    localparam int LETTER_W = 5;
    localparam int IDX_W    = 7;

    typedef struct packed {
        logic accept;
        logic word_end;
    } hist_ctrl_t;

endpackage

FILE: sv/aaf_hist.sv
// Letter histogram bank: current and previous word counts, one lane per letter.
// Saturating count update and parallel compare. Depends on aaf_pkg.
module aaf_hist #(
    parameter int ALPHABET_SIZE = 26,
    parameter int MAX_WORD_LEN  = 15
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  aaf_pkg::hist_ctrl_t           ctrl,
    input  logic [aaf_pkg::LETTER_W-1:0]  letter,
    output logic                          all_equal
);

    localparam int CntW = $clog2(MAX_WORD_LEN + 1);

    logic [CntW-1:0] cur_reg  [ALPHABET_SIZE];
    logic [CntW-1:0] prev_reg [ALPHABET_SIZE];
    logic [CntW-1:0] cur_inc  [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] lane_eq;

    genvar k;
    generate
        for (k = 0; k < ALPHABET_SIZE; k++) begin : g_lane
            logic hit;
            assign hit = (aaf_pkg::IDX_W'(letter) == aaf_pkg::IDX_W'(k));
            assign cur_inc[k] = (hit && (cur_reg[k] != CntW'(MAX_WORD_LEN)))
                                ? cur_reg[k] + CntW'(1) : cur_reg[k];
            assign lane_eq[k] = (cur_inc[k] == prev_reg[k]);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    cur_reg[k]  <= '0;
                    prev_reg[k] <= '0;
                end else if (ctrl.accept) begin
                    if (ctrl.word_end) begin
                        prev_reg[k] <= cur_inc[k];
                        cur_reg[k]  <= '0;
                    end else begin
                        cur_reg[k] <= cur_inc[k];
                    end
                end
            end
        end
    endgenerate

    assign all_equal = &lane_eq;

endmodule

FILE: sv/adjacent_anagram_filter_top.sv
// Adjacent anagram filter, top level: handshake, first-word flag, result register.
// m_keep is registered and appears in the cycle after the accepted beat carrying word_end.
// Throughput: one letter per cycle; stalls only while a result waits on m_ready.
// Reset (aresetn low, synchronous) clears both histograms, the first-word flag
// and m_valid. Depends on aaf_pkg and aaf_hist.
module adjacent_anagram_filter_top #(
    parameter int ALPHABET_SIZE = 26,
    parameter int MAX_WORD_LEN  = 15
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [aaf_pkg::LETTER_W-1:0]  s_letter,
    input  logic                          s_word_end,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_keep
);

    aaf_pkg::hist_ctrl_t ctrl;
    logic all_equal;
    logic keep_next;
    logic seen_reg;
    logic m_valid_reg;
    logic m_keep_reg;

    assign s_ready       = !m_valid_reg || m_ready;
    assign ctrl.accept   = s_valid && s_ready;
    assign ctrl.word_end = s_word_end;

    aaf_hist #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .MAX_WORD_LEN  (MAX_WORD_LEN)
    ) u_hist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .letter    (s_letter),
        .all_equal (all_equal)
    );

    assign keep_next = !seen_reg || !all_equal;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (ctrl.accept && s_word_end) begin
            seen_reg    <= 1'b1;
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.accept && s_word_end) begin
            m_keep_reg <= keep_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_keep  = m_keep_reg;

    a_first_word_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.accept && s_word_end && !seen_reg) |=> (m_valid && m_keep))
        else $error("first word not kept");

    a_word_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.accept && s_word_end) |=> (m_valid_reg && seen_reg))
        else $error("word end beat produced no result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input accepted over a stalled result");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_keep_reg)))
        else $error("stalled result changed");

endmodule
